// File: rtl/battery_charge_estimator_assert.svh
// Assertion macros shared by the battery charge estimator RTL.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef BATTERY_CHARGE_ESTIMATOR_ASSERT_SVH
`define BATTERY_CHARGE_ESTIMATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BCE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define BCE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/bce_pkg.sv
// Package for the battery charge estimator: payload types, register types,
// the charge lookup table and arithmetic constants. No dependencies.
`default_nettype none

package bce_pkg;

   // Request and response payloads.
   typedef struct packed {
      logic [11:0] raw_sample;
      logic        read_ok;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] battery_millivolts;
      logic [6:0]  charge_percent;
      logic        fresh;
      logic        low_battery;
      logic        update_allowed;
   } rsp_payload_type;

   // Configuration registers as seen by the back end.
   typedef struct packed {
      logic [7:0]  divider_numerator;
      logic [7:0]  divider_denominator;
      logic [11:0] offset_millivolts;
      logic [6:0]  low_percent_threshold;
      logic [6:0]  update_percent_threshold;
   } csr_regs_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_DIV_NUM    = 3'd0;
   localparam logic [2:0] REG_DIV_DEN    = 3'd1;
   localparam logic [2:0] REG_OFFSET     = 3'd2;
   localparam logic [2:0] REG_LOW_THR    = 3'd3;
   localparam logic [2:0] REG_UPDATE_THR = 3'd4;
   localparam int         CSR_ADDR_W     = 5;

   // Register reset values.
   localparam logic [7:0]  DIV_NUM_RESET    = 8'd2;
   localparam logic [7:0]  DIV_DEN_RESET    = 8'd1;
   localparam logic [11:0] OFFSET_RESET     = 12'd0;
   localparam logic [6:0]  LOW_THR_RESET    = 7'd15;
   localparam logic [6:0]  UPDATE_THR_RESET = 7'd30;

   // Cache reset values.
   localparam logic [15:0] CACHED_MV_RESET  = 16'd4000;
   localparam logic [6:0]  CACHED_PCT_RESET = 7'd80;

   // ADC to pin conversion: raw * 3100 / 4095.
   localparam logic [11:0] PIN_FULL_SCALE_MV = 12'd3100;
   localparam logic [15:0] MV_MAX            = 16'd65535;

   // Shared divider geometry.
   localparam int DIV_DVD_W  = 20;
   localparam int DIV_DVS_W  = 8;
   localparam int DIV_STEP_W = $clog2(DIV_DVD_W);

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Nine-point LiPo discharge curve, highest voltage first.
   localparam int LUT_POINTS = 9;
   localparam int LUT_IDX_W  = $clog2(LUT_POINTS);
   localparam logic [15:0] LUT_MV [0:LUT_POINTS-1] = '{
      16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800,
      16'd3700, 16'd3600, 16'd3500, 16'd3400
   };
   localparam logic [6:0] LUT_PCT [0:LUT_POINTS-1] = '{
      7'd100, 7'd90, 7'd80, 7'd70, 7'd55, 7'd40, 7'd25, 7'd10, 7'd0
   };

   // Every segment spans 100 mV; half of it is the rounding term.
   localparam logic [10:0] LUT_HALF_SPAN = 11'd50;
   // floor(y / 100) equals (y * 41) >> 12 for every y the table produces.
   localparam logic [5:0]  RECIP_100     = 6'd41;

endpackage

`default_nettype wire

// File: rtl/bce_front.sv
// Front end of the battery charge estimator: takes ADC read attempts and
// accumulates the good reads of a burst. Depends on bce_pkg.
`default_nettype none

module bce_front
   import bce_pkg::*;
#(
   parameter int SAMPLES_PER_READING = 8,
   localparam int SUM_W = $clog2(SAMPLES_PER_READING) + 12,
   localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_payload,
   input  logic                   queue_full,
   output logic                   push,
   output logic [SUM_W+CNT_W-1:0] push_data
);

   logic [SUM_W-1:0] sum_ff, sum_in, sum_next;
   logic [CNT_W-1:0] good_ff, good_in, good_next;
   logic [CNT_W-1:0] attempt_ff, attempt_in, attempt_next;
   logic             accept;
   logic             burst_end;

   // A request is taken whenever the queue has room for a finished burst.
   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Running totals including the request on the port.
   always_comb begin
      sum_next     = sum_ff + (req_payload.read_ok ? SUM_W'(req_payload.raw_sample) : '0);
      good_next    = good_ff + CNT_W'(req_payload.read_ok);
      attempt_next = attempt_ff + CNT_W'(1);
      burst_end    = attempt_next >= CNT_W'(SAMPLES_PER_READING);
   end

   // The last attempt of a burst hands the totals to the queue and restarts.
   always_comb begin
      sum_in     = sum_ff;
      good_in    = good_ff;
      attempt_in = attempt_ff;
      if (accept) begin
         if (burst_end) begin
            sum_in     = '0;
            good_in    = '0;
            attempt_in = '0;
         end else begin
            sum_in     = sum_next;
            good_in    = good_next;
            attempt_in = attempt_next;
         end
      end
   end

   assign push      = accept && burst_end;
   assign push_data = {sum_next, good_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff     <= '0;
         good_ff    <= '0;
         attempt_ff <= '0;
      end else begin
         sum_ff     <= sum_in;
         good_ff    <= good_in;
         attempt_ff <= attempt_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bce_queue.sv
// Short first-in first-out queue of burst totals between front and back end.
// Register based; no package dependencies.
`default_nettype none

module bce_queue #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // Pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/bce_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// averaging and divider-ratio steps. Depends on bce_pkg.
`default_nettype none

module bce_divider
   import bce_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_DVD_W-1:0] dividend,
   input  logic [DIV_DVS_W-1:0] divisor,
   output div_status_type       status,
   output logic [DIV_DVD_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_DVS_W-1:0]  rem_ff, rem_in;
   logic [DIV_DVD_W-1:0]  quo_ff, quo_in;
   logic [DIV_DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_DVS_W:0]    trial;
   logic [DIV_DVS_W:0]    diff;
   logic                  fits;

   // Shift the next dividend bit into the remainder and try the subtraction.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
         quo_in  = {quo_ff[DIV_DVD_W-2:0], fits};
         step_in = step_ff + DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(DIV_DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

// File: rtl/bce_back.sv
// Back end of the battery charge estimator: averages a burst, scales it to
// battery millivolts, interpolates charge and holds the response register.
// Depends on bce_pkg, bce_divider and the assertion macro header.
`default_nettype none
`include "battery_charge_estimator_assert.svh"

module bce_back
   import bce_pkg::*;
#(
   parameter int SAMPLES_PER_READING = 8,
   localparam int SUM_W = $clog2(SAMPLES_PER_READING) + 12,
   localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  logic [SUM_W+CNT_W-1:0] q_data,
   output logic                   q_pop,
   input  csr_regs_type           regs,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_payload
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_AVG   = 3'd1;
   localparam logic [2:0] S_PIN   = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_DEN   = 3'd4;
   localparam logic [2:0] S_LUT   = 3'd5;
   localparam logic [2:0] S_PCT   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic             fresh_ff, fresh_in;
   logic [11:0]      avg_ff, avg_in;
   logic [23:0]      prod_ff, prod_in;
   logic [15:0]      mv_ff, mv_in;
   logic [6:0]       base_ff, base_in;
   logic [10:0]      y_ff, y_in;
   logic [15:0]      cached_mv_ff, cached_mv_in;
   logic [6:0]       cached_pct_ff, cached_pct_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic [SUM_W-1:0]     q_sum;
   logic [CNT_W-1:0]     q_count;
   logic                 div_start;
   logic [DIV_DVD_W-1:0] div_dividend;
   logic [DIV_DVS_W-1:0] div_divisor;
   div_status_type       div_stat;
   logic [DIV_DVD_W-1:0] div_quotient;

   logic [24:0]          recip_sum;
   logic [11:0]          pin_mv;
   logic [19:0]          scaled_mv;
   logic [7:0]           den_eff;
   logic signed [21:0]   mv_wide;
   logic [LUT_IDX_W-1:0] seg_hi, seg_lo;
   logic [6:0]           seg_rise;
   logic [3:0]           seg_drop;
   logic [16:0]          y_scaled;
   logic                 out_free;
   logic                 div_waiting;

   assign q_sum       = q_data[SUM_W+CNT_W-1:CNT_W];
   assign q_count     = q_data[CNT_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign div_waiting = (state_ff == S_AVG) || (state_ff == S_DEN);

   bce_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quotient)
   );

   // Pin voltage: divide by 4095 as (x + (x >> 12) + 1) >> 12, exact below 4095 * 4096.
   always_comb begin
      recip_sum = 25'(prod_ff) + 25'(prod_ff >> 12) + 25'd1;
      pin_mv    = recip_sum[23:12];
      scaled_mv = 20'(pin_mv) * 20'(regs.divider_numerator);
      den_eff   = (regs.divider_denominator == '0) ? 8'd1 : regs.divider_denominator;
   end

   // Offset added to the divider ratio result; the sequencer saturates the sum.
   always_comb begin
      mv_wide = $signed({2'b00, div_quotient})
              + $signed({{10{regs.offset_millivolts[11]}}, regs.offset_millivolts});
   end

   // Segment search: the deepest table point at or above the voltage.
   always_comb begin
      seg_hi = '0;
      for (int i = 0; i < LUT_POINTS - 1; i++) begin
         if (mv_ff <= LUT_MV[i]) begin
            seg_hi = LUT_IDX_W'(i);
         end
      end
      seg_lo   = seg_hi + LUT_IDX_W'(1);
      seg_rise = 7'(mv_ff - LUT_MV[seg_lo]);
      seg_drop = 4'(LUT_PCT[seg_hi] - LUT_PCT[seg_lo]);
      y_scaled = 17'(y_ff) * 17'(RECIP_100);
   end

   // Sequencer over the steps of one burst.
   always_comb begin
      state_in      = state_ff;
      fresh_in      = fresh_ff;
      avg_in        = avg_ff;
      prod_in       = prod_ff;
      mv_in         = mv_ff;
      base_in       = base_ff;
      y_in          = y_ff;
      cached_mv_in  = cached_mv_ff;
      cached_pct_in = cached_pct_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      div_dividend  = DIV_DVD_W'(q_sum);
      div_divisor   = DIV_DVS_W'(q_count);
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_count == '0) begin
                  fresh_in = 1'b0;
                  state_in = S_OUT;
               end else begin
                  fresh_in  = 1'b1;
                  div_start = 1'b1;
                  state_in  = S_AVG;
               end
            end
         end
         S_AVG: begin
            if (div_stat.done) begin
               avg_in   = div_quotient[11:0];
               state_in = S_PIN;
            end
         end
         S_PIN: begin
            prod_in  = 24'(avg_ff) * 24'(PIN_FULL_SCALE_MV);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            div_start    = 1'b1;
            div_dividend = scaled_mv;
            div_divisor  = den_eff;
            state_in     = S_DEN;
         end
         S_DEN: begin
            if (div_stat.done) begin
               if (mv_wide < 0) begin
                  mv_in = '0;
               end else if (mv_wide > $signed({6'd0, MV_MAX})) begin
                  mv_in = MV_MAX;
               end else begin
                  mv_in = mv_wide[15:0];
               end
               state_in = S_LUT;
            end
         end
         S_LUT: begin
            if (mv_ff >= LUT_MV[0]) begin
               base_in = LUT_PCT[0];
               y_in    = '0;
            end else if (mv_ff <= LUT_MV[LUT_POINTS-1]) begin
               base_in = LUT_PCT[LUT_POINTS-1];
               y_in    = '0;
            end else begin
               base_in = LUT_PCT[seg_lo];
               y_in    = 11'(seg_rise) * 11'(seg_drop) + LUT_HALF_SPAN;
            end
            state_in = S_PCT;
         end
         S_PCT: begin
            cached_mv_in  = mv_ff;
            cached_pct_in = base_ff + 7'(y_scaled >> 12);
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_in.battery_millivolts   = cached_mv_ff;
               rsp_in.charge_percent       = cached_pct_ff;
               rsp_in.fresh                = fresh_ff;
               rsp_in.low_battery          = cached_pct_ff < regs.low_percent_threshold;
               rsp_in.update_allowed       = cached_pct_ff >= regs.update_percent_threshold;
               state_in                    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         cached_mv_ff  <= CACHED_MV_RESET;
         cached_pct_ff <= CACHED_PCT_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cached_mv_ff  <= cached_mv_in;
         cached_pct_ff <= cached_pct_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      fresh_ff <= fresh_in;
      avg_ff   <= avg_in;
      prod_ff  <= prod_in;
      mv_ff    <= mv_in;
      base_ff  <= base_in;
      y_ff     <= y_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The cached charge never leaves the percentage range.
   `BCE_ASSERT_ALWAYS(a_pct_range, clock, reset, cached_pct_ff <= 7'd100, "charge above 100")
   // The divider finishes only while the sequencer waits for it.
   `BCE_ASSERT_IMPLY(a_div_done, clock, reset, div_stat.done, div_waiting, "divider done early")
   // A new division never starts over one still running.
   `BCE_ASSERT_IMPLY(a_div_idle, clock, reset, div_start, !div_stat.busy, "start while busy")

endmodule

`default_nettype wire

// File: rtl/battery_charge_estimator.sv
// With the back end idle, a burst's result is registered after its last request is taken,
// through the averaging division, the divider-ratio division and the sequencing steps; if no
// read in the burst succeeded, the cached result is registered without conversion. Requests
// are taken one per cycle while the queue has room; the back end converts one burst at a time
// and pops a new burst only once the last one is out. Depends on bce_pkg and the parts.
// Reset (synchronous): registers at their defaults, totals cleared, cache 4000 mV / 80 %.
`default_nettype none

module battery_charge_estimator
   import bce_pkg::*;
#(
   parameter int SAMPLES_PER_READING = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int SUM_W = $clog2(SAMPLES_PER_READING) + 12;
   localparam int CNT_W = $clog2(SAMPLES_PER_READING + 1);

   csr_regs_type           regs_ff, regs_in;
   logic                   csr_write;
   logic [2:0]             csr_index;
   logic                   push, queue_full, pop, queue_valid;
   logic [SUM_W+CNT_W-1:0] push_data, pop_data;

   // Configuration registers: written in the access phase of a write.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DIV_NUM:    regs_in.divider_numerator        = csr_pwdata[7:0];
            REG_DIV_DEN:    regs_in.divider_denominator      = csr_pwdata[7:0];
            REG_OFFSET:     regs_in.offset_millivolts        = csr_pwdata[11:0];
            REG_LOW_THR:    regs_in.low_percent_threshold    = csr_pwdata[6:0];
            REG_UPDATE_THR: regs_in.update_percent_threshold = csr_pwdata[6:0];
            default:        regs_in = regs_ff;
         endcase
      end
   end

   // Register read back; the offset reads sign extended.
   always_comb begin
      unique case (csr_index)
         REG_DIV_NUM:    csr_prdata = 32'(regs_ff.divider_numerator);
         REG_DIV_DEN:    csr_prdata = 32'(regs_ff.divider_denominator);
         REG_OFFSET:     csr_prdata = {{20{regs_ff.offset_millivolts[11]}},
                                       regs_ff.offset_millivolts};
         REG_LOW_THR:    csr_prdata = 32'(regs_ff.low_percent_threshold);
         REG_UPDATE_THR: csr_prdata = 32'(regs_ff.update_percent_threshold);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.divider_numerator        <= DIV_NUM_RESET;
         regs_ff.divider_denominator      <= DIV_DEN_RESET;
         regs_ff.offset_millivolts        <= OFFSET_RESET;
         regs_ff.low_percent_threshold    <= LOW_THR_RESET;
         regs_ff.update_percent_threshold <= UPDATE_THR_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

   // Accumulator, burst queue and conversion back end.
   bce_front #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   bce_queue #(
      .WIDTH (SUM_W + CNT_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .pop_data  (pop_data)
   );

   bce_back #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (queue_valid),
      .q_data      (pop_data),
      .q_pop       (pop),
      .regs        (regs_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
